### rtl/core/fpa_pkg.sv
// Shared types, codes and defaults for the fit-policy partition allocator.
package fpa_pkg;

  // Default configuration of the block.
  localparam int NUM_PARTS_DEF = 8;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed port field widths.
  localparam int KIND_W = 1;
  localparam int SEL_W  = 3;
  localparam int SIZE_W = 16;
  localparam int POL_W  = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

  // Placement policies. The unused code behaves as first fit.
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } state_t;

endpackage

### rtl/core/fpa_table.sv
// Free-size table: synchronous memory with per-entry valid bits that read as zero.
module fpa_table #(
  parameter int NUM_PARTS = fpa_pkg::NUM_PARTS_DEF,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [((NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1)-1:0] wr_addr,
  input  logic [SIZE_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [((NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1)-1:0] rd_addr,
  output logic [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0] mem_r [NUM_PARTS];
  logic [NUM_PARTS-1:0] valid_r;
  logic [SIZE_BITS-1:0] rd_q_r;
  logic                 rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : '0;

endmodule

### rtl/core/fit_policy_partition_allocator.sv
// Top level of the fit-policy partition allocator: sequencer, scan datapath and result register.
//
// The block keeps one free size per fixed partition in a small synchronous memory.
// A load beat writes one partition's free size and its result appears on the cycle
// after it is accepted; a load whose partition number is not below NUM_PARTS is
// dropped and reported as not granted. Busy stays low after a load, so loads may
// be issued every cycle. An allocate beat scans the whole table, one entry read per
// cycle through the memory's single read port, and picks a partition by the policy
// in cfg_data: first fit takes the lowest fitting index, best fit the smallest
// fitting size and worst fit the largest, with the lowest index winning a tie; the
// unused policy code acts as first fit. A request of zero fits every partition and
// leaves the table unchanged. An allocate holds busy high through the scan state
// (one read per entry), a drain state for the last read to come back and be
// compared, and a write-back state that writes the reduced size back; its
// result strobes out on the cycle busy falls, which is also the first cycle a new
// beat can be taken. Each result is shown on out_strobe for exactly one cycle and must be
// captured then, since the receiver cannot stall the block. When nothing is placed,
// granted, part_index and remaining are all zero. The user must write the policy register
// through cfg_we only while the block is idle; the block does not enforce it. No clearing
// pass follows reset: per-entry valid bits make every partition read as zero until loaded.
module fit_policy_partition_allocator #(
  parameter int NUM_PARTS = fpa_pkg::NUM_PARTS_DEF,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [fpa_pkg::KIND_W-1:0] in_kind,
  input  logic [fpa_pkg::SEL_W-1:0]  in_part_select,
  input  logic [fpa_pkg::SIZE_W-1:0] in_size_value,
  output logic                      out_strobe,
  output logic                      out_granted,
  output logic [fpa_pkg::SEL_W-1:0]  out_part_index,
  output logic [fpa_pkg::SIZE_W-1:0] out_remaining,
  input  logic                      cfg_we,
  input  logic [fpa_pkg::POL_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTS - 1);

  fpa_pkg::state_t state_r, state_nxt;

  logic [fpa_pkg::POL_W-1:0] policy_r;

  logic [IDX_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] pick_val_r, pick_val_nxt;
  logic                 cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;

  logic                      out_strobe_r, out_strobe_nxt;
  logic                      out_granted_r, out_granted_nxt;
  logic [fpa_pkg::SEL_W-1:0]  out_index_r, out_index_nxt;
  logic [fpa_pkg::SIZE_W-1:0] out_rem_r, out_rem_nxt;

  logic                 accept;
  logic                 is_load;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] load_size;
  logic [SIZE_BITS-1:0] wb_size;

  logic                 tbl_wr_en;
  logic [IDX_W-1:0]     tbl_wr_addr;
  logic [SIZE_BITS-1:0] tbl_wr_data;
  logic                 tbl_rd_en;
  logic [SIZE_BITS-1:0] tbl_rd_data;

  logic fits;
  logic take;

  // The table itself: one write port shared by loads and write-back, one read port
  // for the scan. The sequencer never overlaps a write and a read of one entry.
  fpa_table #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (rd_cnt_r),
    .rd_data (tbl_rd_data)
  );

  assign accept    = start && !busy;
  assign is_load   = (in_kind == fpa_pkg::KIND_LOAD);
  assign load_ok   = is_load && (int'(in_part_select) < NUM_PARTS);
  assign load_size = SIZE_BITS'(in_size_value);
  assign wb_size   = pick_val_r - req_r;

  // Candidate test for the entry whose read data is back this cycle. Only the first
  // fitting entry is taken under first fit and the unused code; best and worst fit
  // may replace it on a strict improvement, so ties keep the lower index.
  assign fits = (tbl_rd_data >= req_r);
  assign take = cmp_en_r && fits &&
                (!found_r ||
                 ((policy_r == fpa_pkg::POL_BEST)  && (tbl_rd_data < pick_val_r)) ||
                 ((policy_r == fpa_pkg::POL_WORST) && (tbl_rd_data > pick_val_r)));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpa_pkg::ST_IDLE: begin
        if (accept && !is_load) begin
          state_nxt = fpa_pkg::ST_SCAN;
        end
      end
      fpa_pkg::ST_SCAN: begin
        if (rd_cnt_r == LAST_IDX) begin
          state_nxt = fpa_pkg::ST_DRAIN;
        end
      end
      fpa_pkg::ST_DRAIN: state_nxt = fpa_pkg::ST_WB;
      fpa_pkg::ST_WB:    state_nxt = fpa_pkg::ST_IDLE;
      default:           state_nxt = fpa_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    busy        = 1'b1;
    tbl_rd_en   = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = IDX_W'(in_part_select);
    tbl_wr_data = load_size;
    case (state_r)
      fpa_pkg::ST_IDLE: begin
        busy      = 1'b0;
        tbl_wr_en = accept && load_ok;
      end
      fpa_pkg::ST_SCAN: begin
        tbl_rd_en = 1'b1;
      end
      fpa_pkg::ST_DRAIN: begin
        busy = 1'b1;
      end
      fpa_pkg::ST_WB: begin
        tbl_wr_en   = found_r;
        tbl_wr_addr = pick_r;
        tbl_wr_data = wb_size;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Scan datapath.
  always_comb begin
    rd_cnt_nxt   = (state_r == fpa_pkg::ST_SCAN) ? IDX_W'(rd_cnt_r + 1'b1) : '0;
    req_nxt      = accept ? load_size : req_r;
    found_nxt    = found_r;
    pick_nxt     = pick_r;
    pick_val_nxt = pick_val_r;
    cmp_en_nxt   = (state_r == fpa_pkg::ST_SCAN);
    cmp_idx_nxt  = rd_cnt_r;
    if (accept) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt    = 1'b1;
      pick_nxt     = cmp_idx_r;
      pick_val_nxt = tbl_rd_data;
    end
  end

  // Result register: a load reports on the next cycle, an allocate after write-back.
  always_comb begin
    out_strobe_nxt  = 1'b0;
    out_granted_nxt = 1'b0;
    out_index_nxt   = '0;
    out_rem_nxt     = '0;
    if (accept && is_load) begin
      out_strobe_nxt = 1'b1;
      if (load_ok) begin
        out_granted_nxt = 1'b1;
        out_index_nxt   = in_part_select;
        out_rem_nxt     = fpa_pkg::SIZE_W'(load_size);
      end
    end else if (state_r == fpa_pkg::ST_WB) begin
      out_strobe_nxt = 1'b1;
      if (found_r) begin
        out_granted_nxt = 1'b1;
        out_index_nxt   = fpa_pkg::SEL_W'(pick_r);
        out_rem_nxt     = fpa_pkg::SIZE_W'(wb_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fpa_pkg::ST_IDLE;
      policy_r     <= fpa_pkg::POL_FIRST;
      cmp_en_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_en_r     <= cmp_en_nxt;
      out_strobe_r <= out_strobe_nxt;
      found_r      <= found_nxt;
      if (cfg_we) begin
        policy_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r      <= rd_cnt_nxt;
    req_r         <= req_nxt;
    pick_r        <= pick_nxt;
    pick_val_r    <= pick_val_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    out_granted_r <= out_granted_nxt;
    out_index_r   <= out_index_nxt;
    out_rem_r     <= out_rem_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_granted    = out_granted_r;
  assign out_part_index = out_index_r;
  assign out_remaining  = out_rem_r;

endmodule

### rtl/core/fpa_checker.sv
// Port-level checker for the fit-policy partition allocator, with its bind.
module fpa_checker #(
  parameter int NUM_PARTS = fpa_pkg::NUM_PARTS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [fpa_pkg::KIND_W-1:0] in_kind,
  input logic [fpa_pkg::SEL_W-1:0]  in_part_select,
  input logic                      out_strobe,
  input logic                      out_granted,
  input logic [fpa_pkg::SEL_W-1:0]  out_part_index,
  input logic [fpa_pkg::SIZE_W-1:0] out_remaining
);

  logic acc_load;
  logic acc_alloc;

  assign acc_load  = start && !busy && (in_kind == fpa_pkg::KIND_LOAD);
  assign acc_alloc = start && !busy && (in_kind == fpa_pkg::KIND_ALLOC);

  // An allocate beat holds the block busy for its scan.
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_alloc |=> busy)
    else $error("allocate beat did not raise busy");

  // A load beat reports on the very next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_load |=> out_strobe)
    else $error("load beat gave no result on the next cycle");

  // A load in range is granted and echoes its partition.
  a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_load && (int'(in_part_select) < NUM_PARTS)) |=>
      (out_granted && (out_part_index == $past(in_part_select))))
    else $error("load result does not match the loaded partition");

  // The end of an allocate scan delivers its result.
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy fell without a result");

  // A refused beat carries zero index and zero remaining size.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_granted) |-> ((out_part_index == '0) && (out_remaining == '0)))
    else $error("refused result carries nonzero fields");

endmodule

bind fit_policy_partition_allocator fpa_checker #(
  .NUM_PARTS (NUM_PARTS)
) u_fpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_kind        (in_kind),
  .in_part_select (in_part_select),
  .out_strobe     (out_strobe),
  .out_granted    (out_granted),
  .out_part_index (out_part_index),
  .out_remaining  (out_remaining)
);

### bench/fpa_result_checker.sv
// Checker for the fit-policy partition allocator: predicts each beat's result and compares.
module fpa_result_checker
  import fpa_pkg::*;
#(
  parameter int NUM_PARTS = NUM_PARTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SEL_W-1:0]  in_part_select,
  input  logic [SIZE_W-1:0] in_size_value,
  input  logic              out_strobe,
  input  logic              out_granted,
  input  logic [SEL_W-1:0]  out_part_index,
  input  logic [SIZE_W-1:0] out_remaining,
  input  logic              cfg_we,
  input  logic [POL_W-1:0]  cfg_data,
  output int                mismatches,
  output int                outstanding,
  output int                results_seen
);

  typedef struct packed {
    logic              granted;
    logic [SEL_W-1:0]  part_index;
    logic [SIZE_W-1:0] remaining;
  } placement_t;

  logic [SIZE_W-1:0] free_size [NUM_PARTS];
  logic [POL_W-1:0]  policy;
  placement_t        placement_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] allocator check: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one load or allocate beat to the shadow table and returns its result.
  function automatic placement_t place_or_load(input logic [KIND_W-1:0] kind,
                                               input logic [SEL_W-1:0]  sel,
                                               input logic [SIZE_W-1:0] size);
    placement_t r;
    bit         found;
    int         pick;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    if (kind == KIND_LOAD) begin
      if (int'(sel) < NUM_PARTS) begin
        free_size[sel] = size;
        r.granted      = 1'b1;
        r.part_index   = sel;
        r.remaining    = size;
      end
      return r;
    end
    for (int j = 0; j < NUM_PARTS; j++) begin
      if (free_size[j] >= size) begin
        if (!found) begin
          found = 1'b1;
          pick  = j;
        end else if (policy == POL_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (policy == POL_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
    end
    if (found) begin
      free_size[pick] = free_size[pick] - size;
      r.granted       = 1'b1;
      r.part_index    = SEL_W'(pick);
      r.remaining     = free_size[pick];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (!rst_n) begin
      foreach (free_size[k]) free_size[k] = '0;
      policy = POL_FIRST;
      placement_q.delete();
    end else begin
      if (out_strobe) begin
        results_seen++;
        if (placement_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending (granted %0d part %0d rem %0d)",
                                    out_granted, out_part_index, out_remaining));
        end else begin
          want = placement_q.pop_front();
          if (out_granted !== want.granted)
            report_mismatch($sformatf("granted %0d, expected %0d", out_granted, want.granted));
          if (out_part_index !== want.part_index)
            report_mismatch($sformatf("part_index %0d, expected %0d",
                                      out_part_index, want.part_index));
          if (out_remaining !== want.remaining)
            report_mismatch($sformatf("remaining %0d, expected %0d",
                                      out_remaining, want.remaining));
        end
      end
      if (start && !busy)
        placement_q.push_back(place_or_load(in_kind, in_part_select, in_size_value));
      if (cfg_we)
        policy = cfg_data;
    end
    outstanding = placement_q.size();
  end

endmodule

### bench/tb_fit_policy_partition_allocator.sv
// Testbench top for the fit-policy partition allocator: stimulus, timeout and verdict.
module tb_fit_policy_partition_allocator;
  import fpa_pkg::*;

  localparam int NUM_PARTS   = NUM_PARTS_DEF;
  // SETTLE covers a whole allocate, the result register and any stray strobe we
  // want the checker to see.
  localparam int SETTLE      = NUM_PARTS + 6;
  localparam int SEG_BEATS   = 154;
  // Hard cap on the run, well above what the slowest correct run needs.
  localparam int CYCLE_LIMIT = 250000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [SEL_W-1:0]  in_part_select;
  logic [SIZE_W-1:0] in_size_value;
  logic              out_strobe;
  logic              out_granted;
  logic [SEL_W-1:0]  out_part_index;
  logic [SIZE_W-1:0] out_remaining;
  logic              cfg_we;
  logic [POL_W-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int beats_sent;
  int sender_idle_pct;
  int cycle_count;

  fit_policy_partition_allocator #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS_DEF)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_part_select (in_part_select),
    .in_size_value  (in_size_value),
    .out_strobe     (out_strobe),
    .out_granted    (out_granted),
    .out_part_index (out_part_index),
    .out_remaining  (out_remaining),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  // The checker sees exactly the pins the block sees; it owns all prediction.
  fpa_result_checker #(
    .NUM_PARTS (NUM_PARTS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_part_select (in_part_select),
    .in_size_value  (in_size_value),
    .out_strobe     (out_strobe),
    .out_granted    (out_granted),
    .out_part_index (out_part_index),
    .out_remaining  (out_remaining),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never arrives.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results still pending",
               cycle_count, outstanding);
      $display("tb_fit_policy_partition_allocator failed");
      $finish;
    end
  end

  // Presents one beat and holds it until the block takes it. When the sender
  // idles afterwards, start drops and the fields carry junk the block must
  // ignore. Start is never lowered and raised in the same step: when no idle
  // follows, the next call simply keeps it high.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [SEL_W-1:0] sel,
                           input logic [SIZE_W-1:0] size);
    in_kind        <= kind;
    in_part_select <= sel;
    in_size_value  <= size;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start          <= 1'b0;
      in_kind        <= KIND_W'($urandom);
      in_part_select <= SEL_W'($urandom);
      in_size_value  <= SIZE_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // The policy may only change with the block idle: drain every pending
  // result, let the block settle, then pulse the write enable once.
  task automatic write_policy(input logic [POL_W-1:0] pol);
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_data <= pol;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Sizes lean toward small values so that ties, exact fits and near misses
  // are common, with the extremes and full-width values mixed in.
  function automatic logic [SIZE_W-1:0] pick_size(input bit is_request);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom);
      4, 5, 6: return SIZE_W'($urandom_range(is_request ? 24 : 48));
      7:       return SIZE_W'(1 << $urandom_range(SIZE_W - 1));
      default: return SIZE_W'($urandom_range(4));
    endcase
  endfunction

  // Most traffic is a refill of the whole table followed by a run of
  // requests against it; the rest is stray loads and lone requests.
  task automatic random_segment(input int beats);
    int stop_at;
    int run_len;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          for (int p = 0; p < NUM_PARTS; p++)
            send_beat(KIND_LOAD, SEL_W'(p), pick_size(1'b0));
          run_len = $urandom_range(4, 14);
          repeat (run_len) send_beat(KIND_ALLOC, SEL_W'($urandom), pick_size(1'b1));
        end
        3, 4: send_beat(KIND_LOAD, SEL_W'($urandom), pick_size(1'b0));
        default: send_beat(KIND_ALLOC, SEL_W'($urandom), pick_size(1'b1));
      endcase
    end
  endtask

  initial begin
    logic [POL_W-1:0] pol;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_kind        <= KIND_LOAD;
    in_part_select <= '0;
    in_size_value  <= '0;
    cfg_we         <= 1'b0;
    cfg_data       <= POL_FIRST;
    beats_sent      = 0;
    sender_idle_pct = 7;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First fit on the empty table: a zero request fits even
    // a partition of size zero, a request of one fits nothing.
    write_policy(POL_FIRST);
    send_beat(KIND_ALLOC, 3'd0, 16'd0);
    send_beat(KIND_ALLOC, 3'd5, 16'd1);
    // Fill the table with ties, a zero and both full-size partitions.
    send_beat(KIND_LOAD, 3'd0, 16'd40);
    send_beat(KIND_LOAD, 3'd1, 16'hFFFF);
    send_beat(KIND_LOAD, 3'd2, 16'd25);
    send_beat(KIND_LOAD, 3'd3, 16'd25);
    send_beat(KIND_LOAD, 3'd4, 16'd0);
    send_beat(KIND_LOAD, 3'd5, 16'd90);
    send_beat(KIND_LOAD, 3'd6, 16'hFFFF);
    send_beat(KIND_LOAD, 3'd7, 16'd25);
    // An exact fit of the largest request empties a partition.
    send_beat(KIND_ALLOC, 3'd0, 16'hFFFF);
    send_beat(KIND_ALLOC, 3'd7, 16'd30);
    // Best fit with a three-way tie among the smallest fits, then a zero
    // request that must pick the lowest empty partition.
    write_policy(POL_BEST);
    send_beat(KIND_ALLOC, 3'd0, 16'd20);
    send_beat(KIND_ALLOC, 3'd0, 16'd0);
    // Worst fit takes the largest, then a request nothing can hold.
    write_policy(POL_WORST);
    send_beat(KIND_ALLOC, 3'd0, 16'd1);
    send_beat(KIND_ALLOC, 3'd0, 16'hFFFF);
    // The unused policy code must behave as first fit.
    write_policy(POL_SPARE);
    send_beat(KIND_ALLOC, 3'd0, 16'd25);
    send_beat(KIND_LOAD, 3'd7, 16'hFFFF);
    send_beat(KIND_ALLOC, 3'd0, 16'hFFFF);

    // Random part: three sender idle rates, each run under every policy
    // code, including both ends of the register's range.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 68 : 0;
      for (int p = 0; p < 4; p++) begin
        pol = POL_W'(p);
        write_policy(pol);
        random_segment(SEG_BEATS);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Drove %0d beats under all four policy codes at three sender idle rates.",
             beats_sent);
    $display("Compared %0d results; %0d mismatches reported.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_fit_policy_partition_allocator passed");
    end else begin
      $display("tb_fit_policy_partition_allocator failed");
    end
    $finish;
  end

endmodule

### fit_policy_partition_allocator.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_table.sv
rtl/core/fit_policy_partition_allocator.sv
rtl/core/fpa_checker.sv
bench/fpa_result_checker.sv
bench/tb_fit_policy_partition_allocator.sv
